// File: rtl/core/sled_pkg.sv
// Shared constants for the serpentine error diffusion dither: defaults, opcodes, register map.
`default_nettype none

package sled_pkg;

    // Default sizes of the error line, the colour quantiser and the error words.
    localparam int SLED_MAX_WIDTH  = 1024;
    localparam int SLED_LEVEL_BITS = 7;
    localparam int SLED_ERROR_BITS = 10;

    // Item kinds carried in tuser of the input stream.
    localparam logic [1:0] OP_LOAD_COLOR = 2'd0;
    localparam logic [1:0] OP_LOAD_CODE  = 2'd1;
    localparam logic [1:0] OP_PIXEL      = 2'd2;

    // Register selects, taken from address bit 2.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Register values after reset.
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd1;

    // Largest value of one colour channel.
    localparam int PIXEL_MAX = 255;

endpackage

`default_nettype wire

// File: rtl/core/serpentine_lite_error_diffusion_dither.sv
// Palette dither with Sierra Lite error diffusion over a serpentine pixel scan.
// A pixel's result reaches the output register as phase C completes, and the next pixel is taken
// only then, since the carried-error loop runs through the clamp and the read of the
// nearest-colour memory; table loads are taken one per cycle while idle or as phase C completes.
// Reset: positions and carried error clear, registers return to width 1024 and height 1; the
// error line reads as zero for the first row after reset or a register write, so no clearing pass.
`default_nettype none

module serpentine_lite_error_diffusion_dither
    import sled_pkg::*;
#(
    parameter int MAX_WIDTH  = SLED_MAX_WIDTH,
    parameter int LEVEL_BITS = SLED_LEVEL_BITS,
    parameter int ERROR_BITS = SLED_ERROR_BITS
)(
    input  wire         clk,
    input  wire         rst_n,
    // Input stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: table_index[20:0], table_value[44:21], pixel_rgb[68:45], zero[71:69].
    input  wire  [71:0] s_axis_tdata,
    // tuser: opcode[1:0].
    input  wire  [1:0]  s_axis_tuser,
    // Output stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: palette_code[7:0].
    output logic [7:0]  m_axis_tdata,
    // tlast: end_of_row.
    output logic        m_axis_tlast,
    // tuser: end_of_frame[0].
    output logic        m_axis_tuser,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_BITS    = 3 * LEVEL_BITS;
    localparam int TABLE_DEPTH = 1 << IDX_BITS;
    localparam int XB          = $clog2(MAX_WIDTH);
    localparam int LINE_BITS   = 3 * ERROR_BITS;
    localparam int SUM_BITS    = ERROR_BITS + 2;

    // Each pixel walks through three phases: A forms the corrected colour and reads the
    // nearest-colour memory, B works out the error and reads the code memory, C hands the
    // code to the output register. The next transfer is taken as C completes.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_A,
        ST_B,
        ST_C
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Memories. The colour and code tables are undefined until loaded.
    logic [23:0]          color_mem [TABLE_DEPTH];
    logic [7:0]           code_mem  [TABLE_DEPTH];
    logic [LINE_BITS-1:0] line_mem  [MAX_WIDTH];

    // Registers and frame state.
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [XB-1:0] col_reg;
    logic [15:0]   row_reg;
    logic signed [ERROR_BITS-1:0] carried_reg [3];
    logic fresh_reg;

    // Pixel in flight, captured at acceptance.
    logic [23:0]          pix_rgb_reg;
    logic [XB-1:0]        x_reg;
    logic [XB-1:0]        behind_reg;
    logic                 first_reg;
    logic                 eor_reg;
    logic                 last_row_reg;
    logic                 eof_reg;
    logic [LINE_BITS-1:0] line_rd_reg;

    // Later phases.
    logic [7:0]           val_reg [3];
    logic [23:0]          color_rd_reg;
    logic [7:0]           code_rd_reg;
    logic signed [8:0]    prev_q_reg [3];
    logic [LINE_BITS-1:0] share_reg;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_code_reg;
    logic       out_eor_reg;
    logic       out_eof_reg;

    // Input fields.
    logic [1:0]          in_op;
    logic [20:0]         in_index;
    logic [23:0]         in_value;
    logic [23:0]         in_rgb;
    logic [IDX_BITS-1:0] tbl_addr;

    assign in_op    = s_axis_tuser;
    assign in_index = s_axis_tdata[20:0];
    assign in_value = s_axis_tdata[44:21];
    assign in_rgb   = s_axis_tdata[68:45];
    assign tbl_addr = IDX_BITS'(in_index);

    // Handshakes.
    logic out_free;
    logic c_done;
    logic in_fire;
    logic pix_fire;
    logic cfg_wr;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign c_done        = (state_reg == ST_C) && out_free;
    assign s_axis_tready = (state_reg == ST_IDLE) || c_done;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign pix_fire      = in_fire && (in_op == OP_PIXEL);
    assign cfg_wr        = psel && penable && pwrite;

    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_WIDTH)
        begin
            prdata = {21'd0, image_width_reg};
        end
        else
        begin
            prdata = {16'd0, image_height_reg};
        end
    end

    // Frame geometry. A width of zero behaves as one and a width above the line is cut to it.
    logic [XB-1:0] w_last;
    logic [15:0]   h_last;
    logic          cur_eor;
    logic          cur_last_row;
    logic [XB-1:0] cur_x;
    logic [XB-1:0] cur_behind;

    always_comb
    begin
        if (image_width_reg == 11'd0)
        begin
            w_last = '0;
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w_last = XB'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = XB'(image_width_reg - 11'd1);
        end
    end

    assign h_last       = (image_height_reg == 16'd0) ? 16'd0 : image_height_reg - 16'd1;
    assign cur_eor      = (col_reg == w_last);
    assign cur_last_row = (row_reg == h_last);
    // Odd rows run right to left, so the column count is mirrored there.
    assign cur_x        = row_reg[0] ? (w_last - col_reg) : col_reg;
    // The pixel behind is the one just done in this row; only used when the column is not first.
    assign cur_behind   = row_reg[0] ? (cur_x + XB'(1)) : (cur_x - XB'(1));

    // Phase A: add carried and above-row errors and clamp each channel.
    logic signed [ERROR_BITS-1:0] line_e [3];
    logic signed [SUM_BITS-1:0]   sum_a  [3];
    logic [7:0]                   val_a  [3];
    logic [IDX_BITS-1:0]          idx_a;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            line_e[ch] = $signed(line_rd_reg[(2 - ch) * ERROR_BITS +: ERROR_BITS]);
            sum_a[ch]  = $signed({{(SUM_BITS - 8){1'b0}}, pix_rgb_reg[(2 - ch) * 8 +: 8]})
                       + SUM_BITS'(carried_reg[ch]) + SUM_BITS'(line_e[ch]);
            if (sum_a[ch][SUM_BITS-1])
            begin
                val_a[ch] = 8'd0;
            end
            else if (sum_a[ch] > SUM_BITS'(PIXEL_MAX))
            begin
                val_a[ch] = 8'(PIXEL_MAX);
            end
            else
            begin
                val_a[ch] = sum_a[ch][7:0];
            end
        end
    end

    assign idx_a = {val_a[0][7 -: LEVEL_BITS], val_a[1][7 -: LEVEL_BITS],
                    val_a[2][7 -: LEVEL_BITS]};

    // Phase B: error against the chosen colour, split into half and quarter shares. The
    // arithmetic shift rounds toward minus infinity. All shares stay within plus or minus 128,
    // so they never reach the limits of the error words.
    logic signed [8:0]            delta_b   [3];
    logic signed [8:0]            half_b    [3];
    logic signed [8:0]            quarter_b [3];
    logic signed [9:0]            share_b   [3];
    logic [LINE_BITS-1:0]         x_word_b;
    logic [LINE_BITS-1:0]         share_word_b;
    logic [IDX_BITS-1:0]          code_idx_b;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            delta_b[ch]   = $signed({1'b0, val_reg[ch]})
                          - $signed({1'b0, color_rd_reg[(2 - ch) * 8 +: 8]});
            half_b[ch]    = delta_b[ch] >>> 1;
            quarter_b[ch] = delta_b[ch] >>> 2;
            share_b[ch]   = 10'(prev_q_reg[ch]) + 10'(quarter_b[ch]);
            x_word_b[(2 - ch) * ERROR_BITS +: ERROR_BITS]     = ERROR_BITS'(quarter_b[ch]);
            share_word_b[(2 - ch) * ERROR_BITS +: ERROR_BITS] = ERROR_BITS'(share_b[ch]);
        end
    end

    assign code_idx_b = {color_rd_reg[23 -: LEVEL_BITS], color_rd_reg[15 -: LEVEL_BITS],
                         color_rd_reg[7 -: LEVEL_BITS]};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_fire)
                begin
                    state_next = ST_A;
                end
            end
            ST_A:
            begin
                state_next = ST_B;
            end
            ST_B:
            begin
                state_next = ST_C;
            end
            ST_C:
            begin
                if (c_done)
                begin
                    state_next = pix_fire ? ST_A : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the output register. The result stays until the output transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_code_reg  <= 8'd0;
            out_eor_reg   <= 1'b0;
            out_eof_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (c_done)
            begin
                out_valid_reg <= 1'b1;
                out_code_reg  <= code_rd_reg;
                out_eor_reg   <= eor_reg;
                out_eof_reg   <= eof_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tlast  = out_eor_reg;
    assign m_axis_tuser  = out_eof_reg;

    // Registers, positions and carried error. A register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= 16'd0;
            fresh_reg        <= 1'b1;
            for (int ch = 0; ch < 3; ch++)
            begin
                carried_reg[ch] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                image_width_reg <= pwdata[10:0];
            end
            else
            begin
                image_height_reg <= pwdata[15:0];
            end
            col_reg   <= '0;
            row_reg   <= 16'd0;
            fresh_reg <= 1'b1;
            for (int ch = 0; ch < 3; ch++)
            begin
                carried_reg[ch] <= '0;
            end
        end
        else
        begin
            if (pix_fire)
            begin
                if (cur_eor)
                begin
                    col_reg <= '0;
                    row_reg <= cur_last_row ? 16'd0 : row_reg + 16'd1;
                    // Every entry of the line has been, or with this pixel will be, written since the restart.
                    fresh_reg <= 1'b0;
                end
                else
                begin
                    col_reg <= col_reg + XB'(1);
                end
            end
            if (state_reg == ST_B)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    carried_reg[ch] <= eor_reg ? '0 : ERROR_BITS'(half_b[ch]);
                end
            end
        end
    end

    // Pixel in flight, held from acceptance until the next pixel transfer.
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            pix_rgb_reg  <= in_rgb;
            x_reg        <= cur_x;
            behind_reg   <= cur_behind;
            first_reg    <= (col_reg == '0);
            eor_reg      <= cur_eor;
            last_row_reg <= cur_last_row;
            eof_reg      <= cur_eor && cur_last_row;
        end
    end

    // Nearest-colour memory: loads write at acceptance, phase A reads.
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_op == OP_LOAD_COLOR))
        begin
            color_mem[tbl_addr] <= in_value;
        end
        if (state_reg == ST_A)
        begin
            color_rd_reg <= color_mem[idx_a];
            val_reg      <= val_a;
        end
    end

    // Code memory: loads write at acceptance, phase B reads with the chosen colour.
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_op == OP_LOAD_CODE))
        begin
            code_mem[tbl_addr] <= in_value[7:0];
        end
        if (state_reg == ST_B)
        begin
            code_rd_reg  <= code_mem[code_idx_b];
            share_reg    <= share_word_b;
            prev_q_reg   <= quarter_b;
        end
    end

    // Error line. The entry under the pixel is read at acceptance and rewritten in phase B;
    // the entry behind gains its second quarter share as phase C completes. The next pixel
    // can only need the entry under this one (at a row turn), which phase B has already
    // written by the time it is read, so no forwarding path is needed.
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            line_rd_reg <= fresh_reg ? '0 : line_mem[cur_x];
        end
        if (state_reg == ST_B)
        begin
            line_mem[x_reg] <= last_row_reg ? '0 : x_word_b;
        end
        else if (c_done && !first_reg && !last_row_reg)
        begin
            line_mem[behind_reg] <= share_reg;
        end
    end

    // The column count never passes the last column of the row.
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= w_last)
        else $error("column position beyond row end");

    // The row count never passes the last row of the frame.
    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= h_last)
        else $error("row position beyond frame end");

    // The last pixel of a frame is always also the last of its row.
    assert property (@(posedge clk) disable iff (!rst_n) (m_axis_tvalid && m_axis_tuser)
                     |-> m_axis_tlast)
        else $error("end of frame without end of row");

    // An accepted pixel has its result waiting once phases A, B and C are through without a stall.
    assert property (@(posedge clk) disable iff (!rst_n) pix_fire |-> ##4 m_axis_tvalid)
        else $error("pixel result missing");

endmodule

`default_nettype wire
